### sv/mmfs_pkg.sv
// ----------------------------------------------------------------------------
// mmfs_pkg
// Shared constants, codes and types of the moving-median floor subtractor.
// ----------------------------------------------------------------------------
package mmfs_pkg;

   localparam int MAX_HALF_DEFAULT    = 255;
   localparam int SAMPLE_BITS_DEFAULT = 32;

   localparam int OUT_BITS      = 32;
   localparam int LEN_BITS      = 20;
   localparam int HALF_CFG_BITS = 8;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 20;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_HALF_WIDTH = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_SEQ_LENGTH = CSR_IDX_BITS'(1);

   localparam logic [HALF_CFG_BITS-1:0] HALF_RESET = HALF_CFG_BITS'(3);
   localparam logic [LEN_BITS-1:0]      LEN_RESET  = LEN_BITS'(16);
   localparam logic [LEN_BITS-1:0]      SHORT_SEQ  = LEN_BITS'(16);
   localparam logic [LEN_BITS-1:0]      MIN_HALF   = LEN_BITS'(3);

   // opcodes
   localparam logic OP_PUSH  = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_FETCH_RM,
      ST_SORT,
      ST_FETCH_POS,
      ST_FORM,
      ST_RESULT
   } mmfs_state_type;

   typedef enum logic [1:0] {
      WALK_IDLE,
      WALK_RUN,
      WALK_FLUSH
   } walk_state_type;

   // command from the sequencer to the sorted-window walker
   typedef struct packed {
      logic start;
      logic ins;
      logic rem;
   } walk_ctl_type;

endpackage

### sv/mmfs_ram.sv
// ----------------------------------------------------------------------------
// mmfs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mmfs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 511,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/mmfs_walk.sv
// ----------------------------------------------------------------------------
// mmfs_walk
// Sorted-window walker: one pass over the sorted RAM that drops one copy of
// the leaving sample, merges in the arriving one and picks off the median.
// ----------------------------------------------------------------------------
module mmfs_walk import mmfs_pkg::*; #(
   parameter int WIDTH = SAMPLE_BITS_DEFAULT,
   parameter int DEPTH = 2 * MAX_HALF_DEFAULT + 1,
   localparam int SIZE_BITS = $clog2(DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  walk_ctl_type         ctl,
   input  logic [WIDTH-1:0]     ins_value,
   input  logic [WIDTH-1:0]     rem_value,
   input  logic [SIZE_BITS-1:0] size,
   output logic                 done,
   output logic [WIDTH-1:0]     median
);

   localparam int ADDR_BITS = $clog2(DEPTH);

   walk_state_type       state_ff, state_in;
   logic                 ins_ff, ins_in;
   logic                 rem_ff, rem_in;
   logic [WIDTH-1:0]     ins_val_ff, ins_val_in;
   logic [WIDTH-1:0]     rem_val_ff, rem_val_in;
   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic [SIZE_BITS-1:0] mid_ff, mid_in;
   logic [SIZE_BITS-1:0] issue_ff, issue_in;
   logic [SIZE_BITS-1:0] wr_idx_ff, wr_idx_in;
   logic                 pend_ff, pend_in;
   logic                 inserted_ff, inserted_in;
   logic                 removed_ff, removed_in;
   logic                 carry_vld_ff, carry_vld_in;
   logic [WIDTH-1:0]     carry_ff, carry_in;
   logic [WIDTH-1:0]     median_ff, median_in;

   logic                 wr_en;
   logic [WIDTH-1:0]     wr_data;
   logic                 rd_en;
   logic [WIDTH-1:0]     elem;
   logic                 ins_now;
   logic                 skip_e;
   logic                 keep_e;
   logic [SIZE_BITS:0]   new_size;

   mmfs_ram #(
      .WIDTH(WIDTH),
      .DEPTH(DEPTH)
   ) u_sorted_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_idx_ff[ADDR_BITS-1:0]),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(issue_ff[ADDR_BITS-1:0]),
      .rd_data(elem)
   );

   assign ins_now  = pend_ff && ins_ff && !inserted_ff && (ins_val_ff <= elem);
   assign skip_e   = pend_ff && rem_ff && !removed_ff && (elem == rem_val_ff);
   assign keep_e   = pend_ff && !skip_e;
   assign new_size = (SIZE_BITS + 1)'(size) + (SIZE_BITS + 1)'(ctl.ins)
                     - (SIZE_BITS + 1)'(ctl.rem);

   always_comb begin
      state_in     = state_ff;
      ins_in       = ins_ff;
      rem_in       = rem_ff;
      ins_val_in   = ins_val_ff;
      rem_val_in   = rem_val_ff;
      size_in      = size_ff;
      mid_in       = mid_ff;
      issue_in     = issue_ff;
      wr_idx_in    = wr_idx_ff;
      pend_in      = 1'b0;
      inserted_in  = inserted_ff;
      removed_in   = removed_ff;
      carry_vld_in = carry_vld_ff;
      carry_in     = carry_ff;
      median_in    = median_ff;
      wr_en        = 1'b0;
      wr_data      = carry_ff;
      rd_en        = 1'b0;
      done         = 1'b0;

      unique case (state_ff)
         WALK_IDLE: begin
            if (ctl.start) begin
               ins_in       = ctl.ins;
               rem_in       = ctl.rem;
               ins_val_in   = ins_value;
               rem_val_in   = rem_value;
               size_in      = size;
               mid_in       = new_size[SIZE_BITS:1];
               issue_in     = '0;
               wr_idx_in    = '0;
               inserted_in  = 1'b0;
               removed_in   = 1'b0;
               carry_vld_in = 1'b0;
               state_in     = WALK_RUN;
            end
         end
         WALK_RUN: begin
            if (issue_ff < size_ff) begin
               rd_en    = 1'b1;
               issue_in = issue_ff + SIZE_BITS'(1);
               pend_in  = 1'b1;
            end
            if (pend_ff) begin
               // at most one write per element; one value may wait in carry
               if (carry_vld_ff) begin
                  wr_en        = 1'b1;
                  wr_data      = carry_ff;
                  carry_vld_in = keep_e;
                  carry_in     = elem;
               end else if (ins_now) begin
                  wr_en        = 1'b1;
                  wr_data      = ins_val_ff;
                  carry_vld_in = keep_e;
                  carry_in     = elem;
               end else if (keep_e) begin
                  wr_en   = 1'b1;
                  wr_data = elem;
               end
               inserted_in = inserted_ff || ins_now;
               removed_in  = removed_ff || skip_e;
            end else if (issue_ff == size_ff) begin
               state_in = WALK_FLUSH;
            end
         end
         WALK_FLUSH: begin
            if (carry_vld_ff) begin
               wr_en   = 1'b1;
               wr_data = carry_ff;
            end else if (ins_ff && !inserted_ff) begin
               wr_en   = 1'b1;
               wr_data = ins_val_ff;
            end
            carry_vld_in = 1'b0;
            done         = 1'b1;
            state_in     = WALK_IDLE;
         end
         default: begin
            state_in = WALK_IDLE;
         end
      endcase

      if (wr_en) begin
         wr_idx_in = wr_idx_ff + SIZE_BITS'(1);
         if (wr_idx_ff == mid_ff) begin
            median_in = wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= WALK_IDLE;
         pend_ff      <= 1'b0;
         carry_vld_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         carry_vld_ff <= carry_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      ins_ff      <= ins_in;
      rem_ff      <= rem_in;
      ins_val_ff  <= ins_val_in;
      rem_val_ff  <= rem_val_in;
      size_ff     <= size_in;
      mid_ff      <= mid_in;
      issue_ff    <= issue_in;
      wr_idx_ff   <= wr_idx_in;
      inserted_ff <= inserted_in;
      removed_ff  <= removed_in;
      carry_ff    <= carry_in;
      median_ff   <= median_in;
   end

   assign median = median_ff;

   // writes never overtake reads of the same pass
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wr_idx_ff <= issue_ff))
      else $error("mmfs_walk: write index ahead of read index");

   // the leaving sample must have been found in the window
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == WALK_FLUSH && rem_ff) |-> removed_ff)
      else $error("mmfs_walk: leaving sample not found");

endmodule

### sv/moving_median_floor_subtract_core.sv
// ----------------------------------------------------------------------------
// moving_median_floor_subtract_core
// Flow: a sample of a short sequence (under 16) passes ST_DECIDE and
//   ST_RESULT into the output register; otherwise a transaction passes
//   ST_DECIDE, ST_FETCH_RM, ST_SORT, then ST_FETCH_POS, ST_FORM and ST_RESULT
//   when it gives an output, ST_SORT walking the sorted-window RAM, one entry
//   a cycle, over fill entries (fill at most 2h+1). A new one is taken only in ST_IDLE.
// Reset: synchronous, active high; registers back to 3 and 16, counters and
//   window empty, no clearing pass (the RAMs need none).
// ----------------------------------------------------------------------------
module moving_median_floor_subtract_core import mmfs_pkg::*; #(
   parameter int MAX_HALF    = MAX_HALF_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   // input transactions
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_opcode,
   input  logic [OUT_BITS-1:0]      req_sample_value,
   // result transactions
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [OUT_BITS-1:0]      rsp_floor_removed,
   output logic                     rsp_is_last,
   // register writes
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int RING_DEPTH = 2 * MAX_HALF + 1;
   localparam int PTR_BITS   = $clog2(RING_DEPTH);
   localparam int FILL_BITS  = $clog2(RING_DEPTH + 1);
   localparam int HALF_BITS  = $clog2(MAX_HALF + 1);
   localparam int WIDE_BITS  = SAMPLE_BITS + OUT_BITS;

   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(RING_DEPTH - 1);

   // control state
   mmfs_state_type           state_ff, state_in;
   logic [HALF_CFG_BITS-1:0] half_width_ff, half_width_in;
   logic [LEN_BITS-1:0]      seq_len_ff, seq_len_in;
   logic [HALF_BITS-1:0]     active_half_ff, active_half_in;
   logic [LEN_BITS-1:0]      active_len_ff, active_len_in;
   logic [LEN_BITS-1:0]      samples_ff, samples_in;
   logic [LEN_BITS-1:0]      outputs_ff, outputs_in;
   logic [FILL_BITS-1:0]     fill_ff, fill_in;
   logic [PTR_BITS-1:0]      wr_ptr_ff, wr_ptr_in;  // ring slot of the next sample
   logic [PTR_BITS-1:0]      rm_ptr_ff, rm_ptr_in;  // ring slot of the leaving sample
   logic [PTR_BITS-1:0]      pos_ptr_ff, pos_ptr_in; // ring slot of the next output
   logic                     rsp_valid_ff, rsp_valid_in;

   // per-transaction payload
   logic                     op_ff, op_in;
   logic [SAMPLE_BITS-1:0]   x_ff, x_in;
   logic                     ins_ff, ins_in;
   logic                     rem_ff, rem_in;
   logic                     out_ff, out_in;
   logic [OUT_BITS-1:0]      res_val_ff, res_val_in;
   logic                     res_last_ff, res_last_in;
   logic [OUT_BITS-1:0]      rsp_val_ff, rsp_val_in;
   logic                     rsp_last_ff, rsp_last_in;

   // ring RAM and walker hookup
   logic                     ring_wr_en;
   logic                     ring_rd_en;
   logic [PTR_BITS-1:0]      ring_rd_addr;
   logic [SAMPLE_BITS-1:0]   ring_rd_data;
   walk_ctl_type             walk_ctl;
   logic                     walk_done;
   logic [SAMPLE_BITS-1:0]   walk_median;

   // sequence-start values
   logic [LEN_BITS-1:0]      n_start;
   logic [LEN_BITS-1:0]      h_lo;
   logic [LEN_BITS-1:0]      h_mid;
   logic [LEN_BITS-1:0]      h_cap;
   logic [LEN_BITS-1:0]      h_start;

   // helpers
   logic [WIDE_BITS-1:0]     x_wide;
   logic [SAMPLE_BITS-1:0]   diff;
   logic [WIDE_BITS-1:0]     diff_wide;
   logic [WIDE_BITS-1:0]     short_wide;
   logic [LEN_BITS-1:0]      h_ext;
   logic [LEN_BITS-1:0]      len_last;
   logic                     is_short;
   logic                     seq_idle;

   assign csr_ready = 1'b1;

   // sample kept to SAMPLE_BITS; results kept to 32 bits
   assign x_wide     = {{SAMPLE_BITS{1'b0}}, req_sample_value};
   assign diff       = (ring_rd_data > walk_median) ? (ring_rd_data - walk_median)
                                                    : '0;
   assign diff_wide  = {{OUT_BITS{1'b0}}, diff};
   assign short_wide = {{OUT_BITS{1'b0}}, x_ff};

   // zero length counts as one; half width is clamped to MIN_HALF..MAX_HALF, then fits the length
   assign n_start = (seq_len_ff == '0) ? LEN_BITS'(1) : seq_len_ff;
   assign h_lo    = (LEN_BITS'(half_width_ff) < MIN_HALF) ? MIN_HALF
                                                          : LEN_BITS'(half_width_ff);
   assign h_mid   = (h_lo > LEN_BITS'(MAX_HALF)) ? LEN_BITS'(MAX_HALF) : h_lo;
   assign h_cap   = (n_start - LEN_BITS'(1)) >> 1;
   assign h_start = (h_mid > h_cap) ? h_cap : h_mid;

   assign h_ext    = LEN_BITS'(active_half_ff);
   assign len_last = active_len_ff - LEN_BITS'(1);
   assign is_short = active_len_ff < SHORT_SEQ;
   assign seq_idle = (samples_ff == '0) && (outputs_ff == '0);

   mmfs_ram #(
      .WIDTH(SAMPLE_BITS),
      .DEPTH(RING_DEPTH)
   ) u_ring_ram (
      .clock  (clock),
      .wr_en  (ring_wr_en),
      .wr_addr(wr_ptr_ff),
      .wr_data(x_ff),
      .rd_en  (ring_rd_en),
      .rd_addr(ring_rd_addr),
      .rd_data(ring_rd_data)
   );

   mmfs_walk #(
      .WIDTH(SAMPLE_BITS),
      .DEPTH(RING_DEPTH)
   ) u_walk (
      .clock    (clock),
      .reset    (reset),
      .ctl      (walk_ctl),
      .ins_value(x_ff),
      .rem_value(ring_rd_data),
      .size     (fill_ff),
      .done     (walk_done),
      .median   (walk_median)
   );

   // sequencer
   always_comb begin
      state_in       = state_ff;
      half_width_in  = half_width_ff;
      seq_len_in     = seq_len_ff;
      active_half_in = active_half_ff;
      active_len_in  = active_len_ff;
      samples_in     = samples_ff;
      outputs_in     = outputs_ff;
      fill_in        = fill_ff;
      wr_ptr_in      = wr_ptr_ff;
      rm_ptr_in      = rm_ptr_ff;
      pos_ptr_in     = pos_ptr_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      op_in          = op_ff;
      x_in           = x_ff;
      ins_in         = ins_ff;
      rem_in         = rem_ff;
      out_in         = out_ff;
      res_val_in     = res_val_ff;
      res_last_in    = res_last_ff;
      rsp_val_in     = rsp_val_ff;
      rsp_last_in    = rsp_last_ff;
      ring_wr_en     = 1'b0;
      ring_rd_en     = 1'b0;
      ring_rd_addr   = rm_ptr_ff;
      walk_ctl       = '0;
      req_stall      = (state_ff != ST_IDLE);

      // register writes are to arrive only while idle; the block itself does not enforce this
      if (csr_valid) begin
         unique case (csr_index)
            CSR_HALF_WIDTH: half_width_in = csr_wdata[HALF_CFG_BITS-1:0];
            CSR_SEQ_LENGTH: seq_len_in    = csr_wdata[LEN_BITS-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in = req_opcode;
               x_in  = x_wide[SAMPLE_BITS-1:0];
               // first push of a sequence latches length and half width
               if (req_opcode == OP_PUSH && seq_idle) begin
                  active_len_in  = n_start;
                  active_half_in = h_start[HALF_BITS-1:0];
               end
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_IDLE;
            unique case (op_ff)
               OP_PUSH: begin
                  // pushes beyond the length are dropped
                  if (samples_ff < active_len_ff) begin
                     samples_in = samples_ff + LEN_BITS'(1);
                     if (is_short) begin
                        res_val_in  = short_wide[OUT_BITS-1:0];
                        res_last_in = (samples_ff == len_last);
                        outputs_in  = outputs_ff + LEN_BITS'(1);
                        if (samples_ff == len_last) begin
                           samples_in = '0;
                           outputs_in = '0;
                        end
                        state_in = ST_RESULT;
                     end else begin
                        ins_in     = 1'b1;
                        rem_in     = samples_ff >= LEN_BITS'({active_half_ff, 1'b1});
                        out_in     = samples_ff >= h_ext;
                        ring_rd_en = 1'b1;
                        state_in   = ST_FETCH_RM;
                     end
                  end
               end
               OP_DRAIN: begin
                  // drains count only once all samples are in, and never in a short sequence
                  if (!is_short && samples_ff == active_len_ff &&
                      outputs_ff < active_len_ff) begin
                     ins_in     = 1'b0;
                     rem_in     = outputs_ff >= (h_ext + LEN_BITS'(1));
                     out_in     = 1'b1;
                     ring_rd_en = 1'b1;
                     state_in   = ST_FETCH_RM;
                  end
               end
               default: ;
            endcase
         end
         ST_FETCH_RM: begin
            // leaving sample is on the read port; the new one may reuse its slot
            walk_ctl.start = 1'b1;
            walk_ctl.ins   = ins_ff;
            walk_ctl.rem   = rem_ff;
            if (ins_ff) begin
               ring_wr_en = 1'b1;
               wr_ptr_in  = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_BITS'(1);
            end
            if (rem_ff) begin
               rm_ptr_in = (rm_ptr_ff == PTR_LAST) ? '0 : rm_ptr_ff + PTR_BITS'(1);
            end
            fill_in  = fill_ff + FILL_BITS'(ins_ff) - FILL_BITS'(rem_ff);
            state_in = ST_SORT;
         end
         ST_SORT: begin
            if (walk_done) begin
               state_in = out_ff ? ST_FETCH_POS : ST_IDLE;
            end
         end
         ST_FETCH_POS: begin
            ring_rd_en   = 1'b1;
            ring_rd_addr = pos_ptr_ff;
            state_in     = ST_FORM;
         end
         ST_FORM: begin
            res_val_in  = diff_wide[OUT_BITS-1:0];
            res_last_in = (outputs_ff == len_last);
            outputs_in  = outputs_ff + LEN_BITS'(1);
            pos_ptr_in  = (pos_ptr_ff == PTR_LAST) ? '0 : pos_ptr_ff + PTR_BITS'(1);
            if (outputs_ff == len_last) begin
               samples_in = '0;
               outputs_in = '0;
               fill_in    = '0;
               wr_ptr_in  = '0;
               rm_ptr_in  = '0;
               pos_ptr_in = '0;
            end
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            // output register frees up when empty or taken this cycle
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_val_in   = res_val_ff;
               rsp_last_in  = res_last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         half_width_ff  <= HALF_RESET;
         seq_len_ff     <= LEN_RESET;
         active_half_ff <= '0;
         active_len_ff  <= '0;
         samples_ff     <= '0;
         outputs_ff     <= '0;
         fill_ff        <= '0;
         wr_ptr_ff      <= '0;
         rm_ptr_ff      <= '0;
         pos_ptr_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         half_width_ff  <= half_width_in;
         seq_len_ff     <= seq_len_in;
         active_half_ff <= active_half_in;
         active_len_ff  <= active_len_in;
         samples_ff     <= samples_in;
         outputs_ff     <= outputs_in;
         fill_ff        <= fill_in;
         wr_ptr_ff      <= wr_ptr_in;
         rm_ptr_ff      <= rm_ptr_in;
         pos_ptr_ff     <= pos_ptr_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      x_ff        <= x_in;
      ins_ff      <= ins_in;
      rem_ff      <= rem_in;
      out_ff      <= out_in;
      res_val_ff  <= res_val_in;
      res_last_ff <= res_last_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_floor_removed = rsp_val_ff;
   assign rsp_is_last       = rsp_last_ff;

   // window never grows past 2h+1
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_BITS'({active_half_ff, 1'b1}))
      else $error("mmfs: window fill exceeds 2h+1");

   // outputs never run ahead of samples
   assert property (@(posedge clock) disable iff (reset)
      outputs_ff <= samples_ff)
      else $error("mmfs: more outputs than samples");

   // a result appears only out of the result state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESULT))
      else $error("mmfs: result without result state");

   // the last output leaves the sequence counters cleared
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESULT && res_last_ff) |-> (samples_ff == '0 && outputs_ff == '0))
      else $error("mmfs: counters not cleared at sequence end");

endmodule
